FILE: design/assert_macros.svh
// Assertion macros used by the checker of this project.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define VXG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define VXG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/vxg_pkg.sv
// Shared types and constants of the 4D voxel exposure unit.
// No dependencies; imported by every module of the block but vxg_ram.
package vxg_pkg;

	localparam int COORD_W = 16;
	localparam int EXT_W   = 5;
	localparam int OFF_W   = 5;
	localparam int H1_W    = 10;
	localparam int H2_W    = 15;
	localparam int LIN_W   = 20;
	localparam int TALLY_W = 17;
	localparam int MASK_W  = 8;
	localparam int NB_W    = 8;
	localparam int CMD_W   = 2;

	localparam int AXIS_EXTENT_MAX_DEF = 16;
	localparam int GRID_CAPACITY_DEF   = 65536;
	localparam int QUEUE_DEPTH         = 2;
	localparam int PADDR_W             = 5;
	localparam int PDATA_W             = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET    = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_EXPOSE = 2'd2
	} cmd_e;

	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MIN_W = 3'd3,
		REG_EXT_X = 3'd4,
		REG_EXT_Y = 3'd5,
		REG_EXT_Z = 3'd6,
		REG_EXT_W = 3'd7
	} reg_idx_e;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic signed [COORD_W-1:0] coord_w;
		logic                      solid_value;
	} item_t;

	typedef struct packed {
		logic               in_bounds;
		logic               cell_solid;
		logic [MASK_W-1:0]  exposed_mask;
		logic [TALLY_W-1:0] solid_total;
	} result_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] min_w;
		logic [EXT_W-1:0]          ext_x;
		logic [EXT_W-1:0]          ext_y;
		logic [EXT_W-1:0]          ext_z;
		logic [EXT_W-1:0]          ext_w;
	} cfg_t;

	// Classified command handed from front to back through the queue.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             solid_value;
		logic             in_grid;
		logic [LIN_W-1:0] lin;
		logic [NB_W-1:0]  nb_ok;
		logic [EXT_W-1:0] stride_y;
		logic [H1_W-1:0]  stride_z;
		logic [H2_W-1:0]  stride_w;
	} entry_t;

endpackage

FILE: design/voxel_grid_4d_exposure_unit.sv
// Top level of the 4D voxel occupancy grid with exposure query.
// Depends on vxg_pkg, vxg_front, vxg_fifo, vxg_back (and vxg_ram below it).
//
// Usage:
//   Command channel (item_valid / item_stall / item): one transaction per
//   command - set a cell, query a cell, or read the exposed-side mask of a
//   cell. Result channel (result_valid / result_stall / result): exactly one
//   transaction per command, in command order.
//   APB port: eight registers at byte offsets 0..28 (min x,y,z,w then extent
//   x,y,z,w); write only while no command is in flight. pready is tied high.
// Structure:
//   Front end is a 4-stage index pipeline into a 2-entry queue; the back end
//   is bound by the single-port occupancy RAM, one access per cycle.
//   Back end work per command: no RAM access out of bounds, one read for set
//   and query (plus a write when a set changes the cell), and for exposure of
//   a solid cell the center read plus eight neighbour reads.
// Reset:
//   Registers return to min 0, extent 16; the tally clears and the bitmap is
//   swept to empty one cell per cycle over all GRID_CAPACITY cells (65536 by
//   default), with item_stall high throughout. APB writes are taken as ever.
// Back pressure:
//   A stalled result holds in the output register; the back end then waits,
//   the queue fills, and item_stall rises.
module voxel_grid_4d_exposure_unit #(
	parameter int AXIS_EXTENT_MAX = vxg_pkg::AXIS_EXTENT_MAX_DEF,
	parameter int GRID_CAPACITY   = vxg_pkg::GRID_CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  vxg_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output vxg_pkg::result_t              result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vxg_pkg::PADDR_W-1:0]   paddr,
	input  logic [vxg_pkg::PDATA_W-1:0]   pwdata,
	output logic [vxg_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import vxg_pkg::*;

	cfg_t     cfg_q;
	reg_idx_e reg_sel;
	logic     cfg_wr;
	logic     q_push, q_full, q_pop, q_empty, clearing;
	entry_t   q_in, q_head;

	// Config register file; word index from paddr[4:2].
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_e'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_x <= '0;
			cfg_q.min_y <= '0;
			cfg_q.min_z <= '0;
			cfg_q.min_w <= '0;
			cfg_q.ext_x <= EXT_W'(16);
			cfg_q.ext_y <= EXT_W'(16);
			cfg_q.ext_z <= EXT_W'(16);
			cfg_q.ext_w <= EXT_W'(16);
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_MIN_X: cfg_q.min_x <= pwdata[COORD_W-1:0];
				REG_MIN_Y: cfg_q.min_y <= pwdata[COORD_W-1:0];
				REG_MIN_Z: cfg_q.min_z <= pwdata[COORD_W-1:0];
				REG_MIN_W: cfg_q.min_w <= pwdata[COORD_W-1:0];
				REG_EXT_X: cfg_q.ext_x <= pwdata[EXT_W-1:0];
				REG_EXT_Y: cfg_q.ext_y <= pwdata[EXT_W-1:0];
				REG_EXT_Z: cfg_q.ext_z <= pwdata[EXT_W-1:0];
				REG_EXT_W: cfg_q.ext_w <= pwdata[EXT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Readback: minimums sign-extended, extents zero-extended.
	always_comb begin
		case (reg_sel)
			REG_MIN_X: prdata = PDATA_W'(cfg_q.min_x);
			REG_MIN_Y: prdata = PDATA_W'(cfg_q.min_y);
			REG_MIN_Z: prdata = PDATA_W'(cfg_q.min_z);
			REG_MIN_W: prdata = PDATA_W'(cfg_q.min_w);
			REG_EXT_X: prdata = PDATA_W'(cfg_q.ext_x);
			REG_EXT_Y: prdata = PDATA_W'(cfg_q.ext_y);
			REG_EXT_Z: prdata = PDATA_W'(cfg_q.ext_z);
			REG_EXT_W: prdata = PDATA_W'(cfg_q.ext_w);
			default:   prdata = '0;
		endcase
	end

	// Front: bounds check and linear index; held off during the clear sweep.
	vxg_front #(
		.AXIS_EXTENT_MAX (AXIS_EXTENT_MAX),
		.GRID_CAPACITY   (GRID_CAPACITY)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.hold       (clearing),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (q_push),
		.push_data  (q_in),
		.full       (q_full)
	);

	vxg_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// Back: RAM access sequencer, tally and output register.
	vxg_back #(
		.GRID_CAPACITY (GRID_CAPACITY)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.clearing     (clearing),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: design/vxg_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; used for the occupancy bitmap.
module vxg_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/vxg_front.sv
// Front end: takes commands, bounds-checks them and builds the linear index.
// Depends on vxg_pkg; feeds vxg_fifo.
module vxg_front #(
	parameter int AXIS_EXTENT_MAX = 16,
	parameter int GRID_CAPACITY   = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	input  vxg_pkg::cfg_t   cfg,
	input  logic            hold,
	input  logic            item_valid,
	output logic            item_stall,
	input  vxg_pkg::item_t  item,
	output logic            push,
	output vxg_pkg::entry_t push_data,
	input  logic            full
);
	import vxg_pkg::*;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             solid_value;
		logic [3:0]       ok;
		logic [NB_W-1:0]  nb;
	} ctl_t;

	function automatic logic [EXT_W-1:0] sat_ext(input logic [EXT_W-1:0] e);
		return (32'(e) > 32'(AXIS_EXTENT_MAX)) ? EXT_W'(AXIS_EXTENT_MAX) : e;
	endfunction

	logic             v_s1, v_s2, v_s3, v_s4;
	item_t            item_s1;
	ctl_t             ctl_s2, ctl_s3, ctl_s4;
	logic [OFF_W-1:0] off_s2 [4];
	logic [OFF_W-1:0] offx_s3, offy_s3, offx_s4;
	logic [H1_W-1:0]  sz_s2, sz_s3, sz_s4;
	logic [H1_W-1:0]  h1_s3;
	logic [H2_W-1:0]  sw_s3, sw_s4;
	logic [H2_W-1:0]  h2_s4;

	logic [EXT_W-1:0]      ext [4];
	logic signed [COORD_W-1:0] crd [4];
	logic signed [COORD_W-1:0] mn [4];
	logic signed [COORD_W:0]   dif [4];
	logic [OFF_W-1:0]      off_c [4];
	logic [3:0]            ok_c;
	logic [NB_W-1:0]       nb_c;
	logic                  adv, acc;
	logic [LIN_W-1:0]      lin;

	assign ext[0] = sat_ext(cfg.ext_x);
	assign ext[1] = sat_ext(cfg.ext_y);
	assign ext[2] = sat_ext(cfg.ext_z);
	assign ext[3] = sat_ext(cfg.ext_w);
	assign crd[0] = item_s1.coord_x;
	assign crd[1] = item_s1.coord_y;
	assign crd[2] = item_s1.coord_z;
	assign crd[3] = item_s1.coord_w;
	assign mn[0]  = cfg.min_x;
	assign mn[1]  = cfg.min_y;
	assign mn[2]  = cfg.min_z;
	assign mn[3]  = cfg.min_w;

	// Per-axis offset, range check and neighbour availability.
	always_comb begin
		for (int a = 0; a < 4; a++) begin
			dif[a]   = $signed({crd[a][COORD_W-1], crd[a]}) - $signed({mn[a][COORD_W-1], mn[a]});
			ok_c[a]  = !dif[a][COORD_W] && (dif[a][COORD_W-1:0] < COORD_W'(ext[a]));
			off_c[a] = dif[a][OFF_W-1:0];
			nb_c[2*a]   = (off_c[a] != '0);
			nb_c[2*a+1] = ((6'(off_c[a]) + 6'd1) < 6'(ext[a]));
		end
	end

	assign adv        = !v_s4 || !full;
	assign item_stall = hold || !adv;
	assign acc        = item_valid && !item_stall;
	assign push       = v_s4 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Index built Horner style, spread over the pipeline stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item;

			ctl_s2.cmd         <= item_s1.command;
			ctl_s2.solid_value <= item_s1.solid_value;
			ctl_s2.ok          <= ok_c;
			ctl_s2.nb          <= nb_c;
			for (int a = 0; a < 4; a++) begin
				off_s2[a] <= off_c[a];
			end
			sz_s2 <= H1_W'(ext[0]) * H1_W'(ext[1]);

			ctl_s3  <= ctl_s2;
			offx_s3 <= off_s2[0];
			offy_s3 <= off_s2[1];
			h1_s3   <= H1_W'(off_s2[2]) + H1_W'(ext[2]) * H1_W'(off_s2[3]);
			sz_s3   <= sz_s2;
			sw_s3   <= H2_W'(sz_s2) * H2_W'(ext[2]);

			ctl_s4  <= ctl_s3;
			offx_s4 <= offx_s3;
			h2_s4   <= H2_W'(offy_s3) + H2_W'(ext[1]) * H2_W'(h1_s3);
			sz_s4   <= sz_s3;
			sw_s4   <= sw_s3;
		end
	end

	assign lin = LIN_W'(offx_s4) + LIN_W'(ext[0]) * LIN_W'(h2_s4);

	always_comb begin
		push_data.cmd         = ctl_s4.cmd;
		push_data.solid_value = ctl_s4.solid_value;
		push_data.in_grid     = (&ctl_s4.ok) && (32'(lin) < 32'(GRID_CAPACITY));
		push_data.lin         = lin;
		push_data.nb_ok       = ctl_s4.nb;
		push_data.stride_y    = ext[0];
		push_data.stride_z    = sz_s4;
		push_data.stride_w    = sw_s4;
	end

endmodule

FILE: design/vxg_fifo.sv
// Short queue between front and back ends.
// Depends on vxg_pkg for the entry type and depth.
module vxg_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vxg_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output vxg_pkg::entry_t head,
	output logic            empty
);
	import vxg_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: design/vxg_back.sv
// Back end: clears the bitmap, runs set/query/exposure against the RAM,
// keeps the solid tally and holds the result register. Depends on vxg_pkg, vxg_ram.
module vxg_back #(
	parameter int GRID_CAPACITY = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  vxg_pkg::entry_t  q_head,
	output logic             q_pop,
	output logic             clearing,
	output logic             result_valid,
	input  logic             result_stall,
	output vxg_pkg::result_t result
);
	import vxg_pkg::*;

	localparam int AW = (GRID_CAPACITY > 1) ? $clog2(GRID_CAPACITY) : 1;
	localparam logic [AW-1:0] CLR_LAST = AW'(GRID_CAPACITY - 1);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_LOOK  = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_LAST  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t             state_q;
	entry_t             cur_q;
	logic [AW-1:0]      clr_q;
	logic [2:0]         k_q, pend_k_q;
	logic               pend_q, pend_ok_q;
	logic [MASK_W-1:0]  mask_q;
	logic               cell_q;
	logic [TALLY_W-1:0] tally_q;
	logic               out_valid_q;
	result_t            out_q;

	logic               mem_en, mem_we, mem_wdata, mem_rdata;
	logic [AW-1:0]      mem_addr;
	logic [LIN_W:0]     stride, nb_lin;
	logic               nb_side, nb_ok;
	logic               out_free;

	vxg_ram #(
		.WIDTH (1),
		.DEPTH (GRID_CAPACITY)
	) u_occ (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Neighbour k: axis k/2, side k%2 (0 minus, 1 plus).
	always_comb begin
		case (k_q[2:1])
			2'd0:    stride = (LIN_W+1)'(1);
			2'd1:    stride = (LIN_W+1)'(cur_q.stride_y);
			2'd2:    stride = (LIN_W+1)'(cur_q.stride_z);
			default: stride = (LIN_W+1)'(cur_q.stride_w);
		endcase
		nb_side = k_q[0];
		nb_lin  = nb_side ? ({1'b0, cur_q.lin} + stride) : ({1'b0, cur_q.lin} - stride);
		nb_ok   = cur_q.nb_ok[k_q] && (!nb_side || (32'(nb_lin) < 32'(GRID_CAPACITY)));
	end

	assign out_free = !out_valid_q || !result_stall;
	assign clearing = (state_q == ST_CLEAR);

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = AW'(cur_q.lin);
		mem_wdata = 1'b0;
		q_pop     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_en   = 1'b1;
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			ST_IDLE: begin
				q_pop    = !q_empty;
				mem_en   = !q_empty && q_head.in_grid;
				mem_addr = AW'(q_head.lin);
			end
			ST_LOOK: begin
				if (cur_q.cmd == CMD_SET && cur_q.solid_value != mem_rdata) begin
					mem_en    = 1'b1;
					mem_we    = 1'b1;
					mem_wdata = cur_q.solid_value;
				end
			end
			ST_SCAN: begin
				mem_en   = nb_ok;
				mem_addr = AW'(nb_lin);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			k_q         <= '0;
			pend_q      <= 1'b0;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= (state_q == ST_SCAN);
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= q_head.in_grid ? ST_LOOK : ST_DONE;
					end
				end
				ST_LOOK: begin
					k_q <= '0;
					if (cur_q.cmd == CMD_SET) begin
						if (cur_q.solid_value && !mem_rdata) begin
							tally_q <= tally_q + 1'b1;
						end else if (!cur_q.solid_value && mem_rdata) begin
							tally_q <= tally_q - 1'b1;
						end
						state_q <= ST_DONE;
					end else if (cur_q.cmd == CMD_EXPOSE && mem_rdata) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					k_q <= k_q + 1'b1;
					if (k_q == 3'd7) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pend_ok_q <= nb_ok;
		pend_k_q  <= k_q;
		if (state_q == ST_IDLE && !q_empty) begin
			cur_q  <= q_head;
			cell_q <= 1'b0;
			mask_q <= '0;
		end
		if (state_q == ST_LOOK) begin
			cell_q <= (cur_q.cmd == CMD_SET) ? cur_q.solid_value : mem_rdata;
		end
		// Neighbour data lands in the cycle after its read was issued.
		if (pend_q) begin
			mask_q[pend_k_q] <= !(pend_ok_q && mem_rdata);
		end
		if (state_q == ST_DONE && out_free) begin
			out_q.in_bounds    <= cur_q.in_grid;
			out_q.cell_solid   <= cell_q;
			out_q.exposed_mask <= mask_q;
			out_q.solid_total  <= tally_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

FILE: design/vxg_checker.sv
// Port-level checker for the voxel exposure unit, bound to the top level.
// Depends on vxg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vxg_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input vxg_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input vxg_pkg::result_t result
);
	import vxg_pkg::*;

	logic [3:0]         pending_q;
	logic [TALLY_W-1:0] last_total_q;
	logic               item_acc, res_acc;

	assign item_acc = item_valid && !item_stall;
	assign res_acc  = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			last_total_q <= '0;
		end else begin
			if (item_acc && !res_acc) begin
				pending_q <= pending_q + 1'b1;
			end else if (res_acc && !item_acc) begin
				pending_q <= pending_q - 1'b1;
			end
			if (res_acc) begin
				last_total_q <= result.solid_total;
			end
		end
	end

	`VXG_ASSERT_NEXT(a_res_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

	`VXG_ASSERT_NOW(a_no_orphan, clk, arst_n, result_valid, pending_q != 4'd0, "result without a pending command")

	`VXG_ASSERT_NOW(a_tally_step, clk, arst_n, result_valid, (result.solid_total == last_total_q) || (result.solid_total == TALLY_W'(last_total_q + 1'b1)) || (result.solid_total == TALLY_W'(last_total_q - 1'b1)), "solid total moved by more than one")

	`VXG_ASSERT_NOW(a_oob_clean, clk, arst_n, result_valid && !result.in_bounds, !result.cell_solid && (result.exposed_mask == 8'd0), "out-of-bounds result not empty")

endmodule

bind voxel_grid_4d_exposure_unit vxg_checker u_chk (.*);

FILE: sim/voxel_grid_4d_exposure_unit_test.sv
// Testbench for voxel_grid_4d_exposure_unit: directed and random set, query and exposure traffic
// checked against an in-bench occupancy predictor. Uses only vxg_pkg and the unit itself.
`timescale 1ns / 100ps

module voxel_grid_4d_exposure_unit_test;
	import vxg_pkg::*;

	// Command code 3 has no name in the package; the block treats it as a query.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int CELLS        = GRID_CAPACITY_DEF;
	// The reset sweep alone keeps item_stall high while every cell is cleared.
	localparam int STALL_LIMIT  = 4 * GRID_CAPACITY_DEF + 20000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_SHOWN    = 10;

	// Occupancy predictor plus the queue of results it still owes.
	class voxel_checker;
		bit solid_cell [CELLS];
		logic signed [COORD_W-1:0] lo [4];
		logic [EXT_W-1:0] ext [4];
		int unsigned tally;
		result_t pending_results [$];
		int errors;

		function new();
			foreach (solid_cell[i]) solid_cell[i] = 1'b0;
			for (int a = 0; a < 4; a++) begin
				lo[a]  = '0;
				ext[a] = EXT_W'(AXIS_EXTENT_MAX_DEF);
			end
			tally  = 0;
			errors = 0;
		endfunction

		// Extent as the block uses it: saturated at the axis maximum.
		function int span(int a);
			return (ext[a] > AXIS_EXTENT_MAX_DEF) ? AXIS_EXTENT_MAX_DEF : int'(ext[a]);
		endfunction

		// Linear index, x fastest; offsets are taken in 32 bits so nothing wraps.
		function bit locate_cell(input int c [4], output int unsigned idx);
			int off;
			int unsigned stride;
			idx    = 0;
			stride = 1;
			for (int a = 0; a < 4; a++) begin
				off = c[a] - int'(lo[a]);
				if (off < 0 || off >= span(a))
					return 1'b0;
				idx += int'(off) * stride;
				stride *= span(a);
			end
			return idx < CELLS;
		endfunction

		function void write_reg(reg_idx_e r, logic [PDATA_W-1:0] v);
			if (r <= REG_MIN_W)
				lo[int'(r)] = v[COORD_W-1:0];
			else
				ext[int'(r) - int'(REG_EXT_X)] = v[EXT_W-1:0];
		endfunction

		function void note_command(item_t it);
			int c [4];
			int n [4];
			int unsigned idx;
			int unsigned nidx;
			bit in_grid;
			bit cur_solid;
			logic [MASK_W-1:0] mask;
			result_t r;
			c[0] = int'($signed(it.coord_x));
			c[1] = int'($signed(it.coord_y));
			c[2] = int'($signed(it.coord_z));
			c[3] = int'($signed(it.coord_w));
			idx       = 0;
			in_grid   = locate_cell(c, idx);
			cur_solid = 1'b0;
			mask      = '0;
			if (in_grid) begin
				cur_solid = solid_cell[idx];
				if (it.command == CMD_SET) begin
					if (it.solid_value && !cur_solid)
						tally++;
					else if (!it.solid_value && cur_solid)
						tally--;
					solid_cell[idx] = it.solid_value;
					cur_solid = it.solid_value;
				end else if (it.command == CMD_EXPOSE && cur_solid) begin
					// bit 2*axis+side, side 0 is the minus neighbour
					for (int a = 0; a < 4; a++)
						for (int s = 0; s < 2; s++) begin
							n = c;
							n[a] += (s == 1) ? 1 : -1;
							if (!(locate_cell(n, nidx) && solid_cell[nidx]))
								mask[2*a+s] = 1'b1;
						end
				end
			end
			r.in_bounds    = in_grid;
			r.cell_solid   = cur_solid;
			r.exposed_mask = mask;
			r.solid_total  = TALLY_W'(tally);
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("%0t: result with nothing pending: ib %0b solid %0b mask %02h total %0d",
						$time, got.in_bounds, got.cell_solid, got.exposed_mask, got.solid_total);
				return;
			end
			want = pending_results.pop_front();
			if (got.in_bounds !== want.in_bounds || got.cell_solid !== want.cell_solid ||
					got.exposed_mask !== want.exposed_mask ||
					got.solid_total !== want.solid_total) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("%0t: mismatch exp ib %0b solid %0b mask %02h total %0d / got ib %0b solid %0b mask %02h total %0d",
						$time, want.in_bounds, want.cell_solid, want.exposed_mask, want.solid_total,
						got.in_bounds, got.cell_solid, got.exposed_mask, got.solid_total);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	item_t                item         = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 psel         = 1'b0;
	logic                 penable      = 1'b0;
	logic                 pwrite       = 1'b0;
	logic [PADDR_W-1:0]   paddr        = '0;
	logic [PDATA_W-1:0]   pwdata       = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	voxel_checker sb = new();

	// Idle percentages per cycle; written by the stimulus, read by the drivers.
	int tx_idle_pct   = 0;
	int rx_idle_pct   = 0;
	// Each increment asks the receiver for one long hold-off.
	int pressure_asks = 0;
	int pressure_seen = 0;
	int hold_left     = 0;

	// Recently set cells, packed {w,z,y,x}; random traffic revisits them so
	// exposure commands land on solid cells with solid neighbours.
	logic [4*COORD_W-1:0] recent_cells [$];

	// Geometry per random phase: min x,y,z,w then extent x,y,z,w.
	// Covers the 16-bit extremes, a zero extent (nothing inside) and extents
	// above the axis maximum (saturated). The last phase is drawn at random.
	int phase_cfg [5][8] = '{
		'{-32768, 32767, -3, 100, 4, 3, 2, 1},
		'{7, -9, 0, 32760, 3, 3, 3, 3},
		'{0, 0, 0, 0, 16, 16, 16, 16},
		'{-1, 2, -32768, 5, 0, 4, 31, 2},
		'{100, -100, 32767, -32768, 2, 20, 1, 5}
	};

	voxel_grid_4d_exposure_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side: random stall, or a counted hold-off on request so the
	// block backs up all the way to item_stall while the sender keeps offering.
	always @(posedge clk) begin
		if (pressure_seen != pressure_asks) begin
			pressure_seen <= pressure_asks;
			hold_left     <= HOLD_CYCLES;
			result_stall  <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Result monitor: values sampled at the edge are the pre-edge ones.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	// Watchdog: ends the run once no transaction moves on either channel
	// for too long. The reset sweep is the longest legitimate quiet stretch.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	function automatic item_t cmd_item(logic [CMD_W-1:0] op, int x, int y, int z, int w, bit v);
		item_t it;
		it.command     = op;
		it.coord_x     = COORD_W'(x);
		it.coord_y     = COORD_W'(y);
		it.coord_z     = COORD_W'(z);
		it.coord_w     = COORD_W'(w);
		it.solid_value = v;
		return it;
	endfunction

	// Mostly coordinates in or just around the current box, a good share
	// revisiting recently set cells (or their neighbours), a few fully random.
	function automatic item_t random_item();
		item_t it;
		logic [COORD_W-1:0] co [4];
		logic [4*COORD_W-1:0] pick;
		int roll;
		int a;
		roll = $urandom_range(99);
		if (roll < 40)
			it.command = CMD_SET;
		else if (roll < 60)
			it.command = CMD_QUERY;
		else if (roll < 95)
			it.command = CMD_EXPOSE;
		else
			it.command = CMD_UNUSED;
		it.solid_value = ($urandom_range(99) < 65);
		roll = $urandom_range(99);
		if (roll < 8) begin
			for (a = 0; a < 4; a++)
				co[a] = COORD_W'($urandom);
		end else if (roll < 50 && recent_cells.size() != 0) begin
			pick = recent_cells[$urandom_range(recent_cells.size() - 1)];
			for (a = 0; a < 4; a++)
				co[a] = pick[a*COORD_W +: COORD_W];
			if ($urandom_range(1) == 1) begin
				a = $urandom_range(3);
				co[a] = ($urandom_range(1) == 1) ? co[a] + 1'b1 : co[a] - 1'b1;
			end
		end else begin
			for (a = 0; a < 4; a++)
				co[a] = COORD_W'(int'(sb.lo[a]) + int'($urandom_range(sb.span(a) + 3)) - 2);
		end
		it.coord_x = co[0];
		it.coord_y = co[1];
		it.coord_z = co[2];
		it.coord_w = co[3];
		if (it.command == CMD_SET && it.solid_value) begin
			pick = {co[3], co[2], co[1], co[0]};
			recent_cells.insert(recent_cells.size(), pick);
			if (recent_cells.size() > 32)
				void'(recent_cells.pop_front());
		end
		return it;
	endfunction

	// Offers one command, after random idle cycles, and holds it until taken.
	// Called at a clock edge; returns at the accepting edge with valid still
	// high, so the caller either offers the next command or drops valid.
	task automatic send_command(item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_command(it);
	endtask

	// Waits until every pending result has come back, then writes all eight
	// registers (setup + access cycle each, back to back).
	task automatic configure(input int v [8]);
		item_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 8; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= {reg_idx_e'(i), 2'b00};
			pwdata  <= PDATA_W'(v[i]);
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
			sb.write_reg(reg_idx_e'(i), PDATA_W'(v[i]));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin : stimulus
		int row [8];
		tx_idle_pct = 24;
		rx_idle_pct = 72;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Default 16^4 box; the first command waits out the reset sweep.
		send_command(cmd_item(CMD_QUERY, 0, 0, 0, 0, 1'b0));
		send_command(cmd_item(CMD_EXPOSE, 0, 0, 0, 0, 1'b1));  // empty cell, mask stays 0
		send_command(cmd_item(CMD_SET, 0, 0, 0, 0, 1'b1));
		send_command(cmd_item(CMD_SET, 0, 0, 0, 0, 1'b1));     // already solid, tally unchanged
		send_command(cmd_item(CMD_EXPOSE, 0, 0, 0, 0, 1'b0));  // corner: all eight exposed
		send_command(cmd_item(CMD_SET, 1, 0, 0, 0, 1'b1));
		send_command(cmd_item(CMD_SET, 0, 0, 0, 1, 1'b1));
		send_command(cmd_item(CMD_EXPOSE, 0, 0, 0, 0, 1'b0));  // x+ and w+ now covered
		send_command(cmd_item(CMD_SET, 15, 15, 15, 15, 1'b1));
		send_command(cmd_item(CMD_EXPOSE, 15, 15, 15, 15, 1'b0));
		send_command(cmd_item(CMD_SET, 16, 0, 0, 0, 1'b1));   // out of bounds, rejected
		send_command(cmd_item(CMD_SET, -1, 0, 0, 0, 1'b1));
		send_command(cmd_item(CMD_QUERY, -32768, -32768, -32768, -32768, 1'b1));
		send_command(cmd_item(CMD_EXPOSE, 32767, 32767, 32767, 32767, 1'b1));
		send_command(cmd_item(CMD_UNUSED, 0, 0, 0, 0, 1'b0));   // behaves as a query
		send_command(cmd_item(CMD_SET, 0, 0, 0, 0, 1'b0));     // clear a solid cell
		send_command(cmd_item(CMD_EXPOSE, 1, 0, 0, 0, 1'b0));

		// Box at the coordinate extremes; cells set above are kept and read
		// through the new geometry (linear index 1 is still solid).
		configure(phase_cfg[0]);
		send_command(cmd_item(CMD_SET, -32768, 32767, -3, 100, 1'b1));
		send_command(cmd_item(CMD_SET, -32767, 32767, -3, 100, 1'b1));
		// x-1 lies below the box; y+1 passes 16 bits but is an empty cell inside it
		send_command(cmd_item(CMD_EXPOSE, -32768, 32767, -3, 100, 1'b0));
		send_command(cmd_item(CMD_SET, -32765, 32767, -2, 100, 1'b1));
		send_command(cmd_item(CMD_EXPOSE, -32765, 32767, -2, 100, 1'b0));
		send_command(cmd_item(CMD_QUERY, -32768, -32768, -3, 100, 1'b0));

		// Random phases: sender idles 24 / receiver 72, then the reverse,
		// then no idling. Long receiver hold-offs in the later two modes.
		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				tx_idle_pct = 72;
				rx_idle_pct = 24;
			end
			if (p == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (p < 5) begin
				row = phase_cfg[p];
			end else begin
				for (int a = 0; a < 4; a++) begin
					row[a]     = int'($signed(COORD_W'($urandom)));
					row[a + 4] = $urandom_range(1, 6);
				end
			end
			configure(row);
			if (p == 2 || p == 4)
				pressure_asks++;
			repeat ((p == 3) ? 100 : 220)
				send_command(random_item());
		end

		item_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: voxel_grid_4d_exposure_unit.f
+incdir+design
design/vxg_pkg.sv
design/vxg_ram.sv
design/vxg_front.sv
design/vxg_fifo.sv
design/vxg_back.sv
design/voxel_grid_4d_exposure_unit.sv
design/vxg_checker.sv
sim/voxel_grid_4d_exposure_unit_test.sv
